/* design/ring_fifo_with_drop_count_top_assert.svh */
// assertion macros for the ring fifo top level
// expects clk and arst_n in the scope of use
`ifndef RING_FIFO_WITH_DROP_COUNT_TOP_ASSERT_SVH
`define RING_FIFO_WITH_DROP_COUNT_TOP_ASSERT_SVH

// same-cycle implication
`define RFDC_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define RFDC_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

/* design/rfdc_pkg.sv */
// shared constants and types for the ring fifo with drop count
// no dependencies
package rfdc_pkg;

	localparam int SLOTS      = 16;
	localparam int DATA_W     = 64;
	localparam int WORD_W     = 64;
	localparam int CNT_W      = 64;
	localparam int OCC_W      = 4;
	localparam int IDX_W      = (SLOTS > 1) ? $clog2(SLOTS) : 1;
	localparam int OCC_EXT_W  = (IDX_W > OCC_W) ? IDX_W : OCC_W;

	localparam logic KIND_PUSH = 1'b0;
	localparam logic KIND_POP  = 1'b1;

	typedef logic [IDX_W-1:0] idx_t;
	typedef logic [CNT_W-1:0] cnt_t;

	typedef struct packed {
		logic ok;
		logic pop_ok;
		logic wr_en;
		idx_t wr_addr;
		logic rd_en;
		idx_t rd_addr;
	} rfdc_ctl_t;

	typedef struct packed {
		logic [OCC_W-1:0] occupancy;
		cnt_t             pushed;
		cnt_t             popped;
		cnt_t             dropped;
	} rfdc_stats_t;

endpackage

/* design/rfdc_ram.sv */
// generic single write port ram with one registered read port
// no dependencies
module rfdc_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                             clk,
	input  logic                             we,
	input  logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] waddr,
	input  logic [WIDTH-1:0]                 wdata,
	input  logic                             re,
	input  logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] raddr,
	output logic [WIDTH-1:0]                 rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

/* design/rfdc_ctrl.sv */
// read and write indices, transaction counters and push/pop decision
// depends on rfdc_pkg
module rfdc_ctrl import rfdc_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        vld_s1,
	input  logic        kind_s1,
	output rfdc_ctl_t   ctl,
	output rfdc_stats_t stats
);

	idx_t rd_q, wr_q;
	cnt_t push_q, pop_q, drop_q;

	idx_t rd_d, wr_d;
	cnt_t push_d, pop_d, drop_d;
	logic full, empty, push_ok, pop_ok, drop;
	logic [OCC_EXT_W-1:0] occ_ext;

	always_comb begin
		full    = (idx_t'(wr_q + idx_t'(1)) == rd_q);
		empty   = (rd_q == wr_q);
		push_ok = vld_s1 && (kind_s1 == KIND_PUSH) && !full;
		drop    = vld_s1 && (kind_s1 == KIND_PUSH) && full;
		pop_ok  = vld_s1 && (kind_s1 == KIND_POP) && !empty;

		wr_d   = push_ok ? idx_t'(wr_q + idx_t'(1)) : wr_q;
		rd_d   = pop_ok ? idx_t'(rd_q + idx_t'(1)) : rd_q;
		push_d = push_ok ? push_q + cnt_t'(1) : push_q;
		pop_d  = pop_ok ? pop_q + cnt_t'(1) : pop_q;
		drop_d = drop ? drop_q + cnt_t'(1) : drop_q;

		occ_ext = OCC_EXT_W'(idx_t'(wr_d - rd_d));

		ctl.ok      = push_ok || pop_ok;
		ctl.pop_ok  = pop_ok;
		ctl.wr_en   = push_ok;
		ctl.wr_addr = wr_q;
		ctl.rd_en   = pop_ok;
		ctl.rd_addr = rd_q;

		stats.occupancy = occ_ext[OCC_W-1:0];
		stats.pushed    = push_d;
		stats.popped    = pop_d;
		stats.dropped   = drop_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_q   <= '0;
			wr_q   <= '0;
			push_q <= '0;
			pop_q  <= '0;
			drop_q <= '0;
		end else begin
			rd_q   <= rd_d;
			wr_q   <= wr_d;
			push_q <= push_d;
			pop_q  <= pop_d;
			drop_q <= drop_d;
		end
	end

endmodule

/* design/ring_fifo_with_drop_count_top.sv */
// a result strobes on done once start is taken, registered through the input stage and then the result stage
// throughput: one push or pop per cycle, busy stays low, no stall either side
// the slot ram read is enabled in the same cycle as the decision, its registered output feeds data_out
// reset clears indices, counters and the stage valids; slot contents are left as is
// top level of the ring fifo with drop count
// depends on rfdc_pkg, rfdc_ram, rfdc_ctrl and the assertion macro header
`include "ring_fifo_with_drop_count_top_assert.svh"

module ring_fifo_with_drop_count_top import rfdc_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	output logic              busy,
	input  logic              kind,
	input  logic [WORD_W-1:0] data_in,
	output logic              done,
	output logic              ok,
	output logic [WORD_W-1:0] data_out,
	output logic [OCC_W-1:0]  occupancy,
	output logic [CNT_W-1:0]  pushed_total,
	output logic [CNT_W-1:0]  popped_total,
	output logic [CNT_W-1:0]  dropped_total
);

	logic              vld_s1, kind_s1;
	logic [DATA_W-1:0] data_s1;
	logic              vld_s2, ok_s2, pop_ok_s2;
	rfdc_stats_t       stats_s2;
	rfdc_ctl_t         ctl;
	rfdc_stats_t       stats;
	logic [DATA_W-1:0] rdata;
	logic              accept;

	assign busy   = 1'b0;
	assign accept = start && !busy;

	// input stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else begin
			vld_s1 <= accept;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			kind_s1 <= kind;
			data_s1 <= data_in[DATA_W-1:0];
		end
	end

	rfdc_ctrl u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.vld_s1  (vld_s1),
		.kind_s1 (kind_s1),
		.ctl     (ctl),
		.stats   (stats)
	);

	rfdc_ram #(
		.WIDTH (DATA_W),
		.DEPTH (SLOTS)
	) u_ram (
		.clk   (clk),
		.we    (ctl.wr_en),
		.waddr (ctl.wr_addr),
		.wdata (data_s1),
		.re    (ctl.rd_en),
		.raddr (ctl.rd_addr),
		.rdata (rdata)
	);

	// result stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s2    <= 1'b0;
			ok_s2     <= 1'b0;
			pop_ok_s2 <= 1'b0;
		end else begin
			vld_s2    <= vld_s1;
			ok_s2     <= vld_s1 && ctl.ok;
			pop_ok_s2 <= vld_s1 && ctl.pop_ok;
		end
	end

	always_ff @(posedge clk) begin
		if (vld_s1) begin
			stats_s2 <= stats;
		end
	end

	assign done          = vld_s2;
	assign ok            = ok_s2;
	assign data_out      = pop_ok_s2 ? WORD_W'(rdata) : '0;
	assign occupancy     = stats_s2.occupancy;
	assign pushed_total  = stats_s2.pushed;
	assign popped_total  = stats_s2.popped;
	assign dropped_total = stats_s2.dropped;

	`RFDC_ASSERT_NEXT(a_strobe_follows, vld_s1, done, "result strobe missing after input stage")
	`RFDC_ASSERT_NOW(a_refused_zero, done && !ok, data_out == '0, "refused transaction has data")
	`RFDC_ASSERT_NOW(a_write_on_push, ctl.wr_en, vld_s1 && (kind_s1 == KIND_PUSH) && !ctl.pop_ok,
		"ram write without a push")

endmodule
